FILE: hdl/fqpurge_pkg.sv
// types, constants and helpers shared by the purge fifo
package fqpurge_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int OUT_W  = 7;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_PURGE   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ_RD,
        S_PURGE,
        S_HOLD
    } state_t;

    // first member sits in the top bits, so data_out lands in the lowest bits
    typedef struct packed {
        logic [OUT_W-1:0]  occupancy;
        logic [OUT_W-1:0]  removed_count;
        status_t           status;
        logic [WORD_W-1:0] data_out;
    } result_t;

    localparam int RES_W = $bits(result_t);

    // circular slot of the word at offset off behind the head
    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                  input logic [CNT_W-1:0]  off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return ADDR_W'(sum);
    endfunction

    function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] head);
        logic [ADDR_W-1:0] nxt;
        if (head == ADDR_W'(DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = head + ADDR_W'(1);
        end
        return nxt;
    endfunction

endpackage

FILE: hdl/fifo_queue_with_purge_by_value.sv
// purge fifo: circular word store with enqueue, dequeue and purge by value
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | tuser: operation, tdata: value
//  m_      | out | m_tvalid/m_tready  | tdata: data_out, status, removed_count, occupancy
//
// enqueue, failed operations and the unused code finish in the cycle they are accepted;
// dequeue finishes in S_DEQ_RD, after the registered read of the word store
// purge reads one stored word per cycle and writes survivors back
// reset clears head, count and the output valid flag; the word store is not cleared
// an output register holds a finished result; a new beat is taken while it waits,
// and a second result stalls in S_HOLD until the output slot drains
module fifo_queue_with_purge_by_value (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fqpurge_pkg::WORD_W-1:0]    s_tdata,   // [31:0] value
    input  logic [1:0]                        s_tuser,   // [1:0] operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fqpurge_pkg::RES_W-1:0]     m_tdata    // [31:0] data_out, [33:32] status,
                                                         // [40:34] removed_count,
                                                         // [47:41] occupancy
);
    import fqpurge_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] mem_rdata_reg;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [WORD_W-1:0] mem_wdata;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]  kept_reg, kept_next;
    logic [CNT_W-1:0]  removed_reg, removed_next;
    logic [WORD_W-1:0] purge_val_reg, purge_val_next;
    result_t           res_reg, res_next;
    logic              m_valid_reg;
    result_t           m_data_reg;

    logic accept;
    logic out_free;
    logic done;
    logic load_out;
    op_t  op;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign op       = op_t'(s_tuser);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // word store, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && !done) begin
                    state_next = (op == OP_DEQUEUE) ? S_DEQ_RD : S_PURGE;
                end else if (done && !out_free) begin
                    state_next = S_HOLD;
                end
            end
            S_DEQ_RD: begin
                state_next = out_free ? S_IDLE : S_HOLD;
            end
            S_PURGE: begin
                if (done) begin
                    state_next = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        logic [CNT_W-1:0] k;
        logic [CNT_W-1:0] r;
        head_next      = head_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        kept_next      = kept_reg;
        removed_next   = removed_reg;
        purge_val_next = purge_val_reg;
        res_next       = res_reg;
        done           = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = '0;
        mem_raddr      = '0;
        mem_wdata      = s_tdata;
        k              = kept_reg;
        r              = removed_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_next.data_out      = '0;
                    res_next.status        = ST_OK;
                    res_next.removed_count = '0;
                    res_next.occupancy     = OUT_W'(count_reg);
                    unique case (op)
                        OP_ENQUEUE: begin
                            done = 1'b1;
                            if (count_reg >= CNT_W'(DEPTH)) begin
                                res_next.status = ST_FULL;
                            end else begin
                                mem_we             = 1'b1;
                                mem_waddr          = slot_of(head_reg, count_reg);
                                count_next         = count_reg + CNT_W'(1);
                                res_next.occupancy = OUT_W'(count_reg + CNT_W'(1));
                            end
                        end
                        OP_DEQUEUE: begin
                            if (count_reg == '0) begin
                                done            = 1'b1;
                                res_next.status = ST_EMPTY;
                            end else begin
                                mem_re             = 1'b1;
                                mem_raddr          = head_reg;
                                head_next          = next_slot(head_reg);
                                count_next         = count_reg - CNT_W'(1);
                                res_next.occupancy = OUT_W'(count_reg - CNT_W'(1));
                            end
                        end
                        OP_PURGE: begin
                            if (count_reg == '0) begin
                                done = 1'b1;
                            end else begin
                                mem_re         = 1'b1;
                                mem_raddr      = head_reg;
                                rd_idx_next    = CNT_W'(1);
                                kept_next      = '0;
                                removed_next   = '0;
                                purge_val_next = s_tdata;
                            end
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_DEQ_RD: begin
                res_next.data_out = mem_rdata_reg;
                done              = 1'b1;
            end
            S_PURGE: begin
                // survivors pack toward the head; the write slot never passes the read slot
                if (mem_rdata_reg == purge_val_reg) begin
                    r = removed_reg + CNT_W'(1);
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = slot_of(head_reg, kept_reg);
                    mem_wdata = mem_rdata_reg;
                    k         = kept_reg + CNT_W'(1);
                end
                kept_next    = k;
                removed_next = r;
                if (rd_idx_reg < count_reg) begin
                    mem_re      = 1'b1;
                    mem_raddr   = slot_of(head_reg, rd_idx_reg);
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end else begin
                    done                   = 1'b1;
                    count_next             = k;
                    res_next.data_out      = '0;
                    res_next.status        = ST_OK;
                    res_next.removed_count = OUT_W'(r);
                    res_next.occupancy     = OUT_W'(k);
                end
            end
            S_HOLD: begin
                done = 1'b0;
            end
            default: begin
                done = 1'b0;
            end
        endcase
    end

    assign load_out = out_free && (done || (state_reg == S_HOLD));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            rd_idx_reg  <= '0;
            kept_reg    <= '0;
            removed_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            rd_idx_reg  <= rd_idx_next;
            kept_reg    <= kept_next;
            removed_reg <= removed_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        purge_val_reg <= purge_val_next;
        res_reg       <= res_next;
        if (load_out) begin
            m_data_reg <= done ? res_next : res_reg;
        end
    end

    // queue never holds more than its capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("word count above capacity");

    // purge walk never reads past the held words
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PURGE) |-> (rd_idx_reg <= count_reg))
        else $error("purge read index past count");

    // every word walked so far is either kept or removed
    a_walk_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PURGE) |->
        ((CNT_W + 1)'(kept_reg) + (CNT_W + 1)'(removed_reg)
            == (CNT_W + 1)'(rd_idx_reg) - (CNT_W + 1)'(1)))
        else $error("purge kept and removed counts out of step");

    // an accepted enqueue with room grows the queue by one word
    a_enq_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (op == OP_ENQUEUE) && (count_reg < CNT_W'(DEPTH)))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("enqueue did not grow the queue");

endmodule

FILE: test/tb_fifo_queue_with_purge_by_value.sv
// testbench for the purge fifo: directed and random beats checked against a mirror queue
`timescale 1ns / 100ps

module tb_fifo_queue_with_purge_by_value;
    import fqpurge_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_PURGE = 2;
    localparam int MODE_FLOOD = 3;

    localparam int RANDOM_BEATS = 1700;
    localparam int SEG_BEATS    = 50;
    localparam int IDLE_PCT     = 29;

    // mirror of the queue plus the results it still owes
    class purge_fifo_mirror;
        logic [WORD_W-1:0] words [DEPTH];
        int                head;
        int                held;
        result_t           pending_results [$];
        int                mismatches;
        int                beats_in;
        int                results_seen;
        int                full_hits;
        int                empty_hits;
        int                purge_hits;
        int                most_removed;

        function new();
            head = 0;
            held = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // apply one accepted operation and queue the result it owes
        function void take_beat(logic [1:0] op, logic [WORD_W-1:0] val);
            result_t           res;
            int                removed;
            int                kept;
            logic [WORD_W-1:0] w;
            res = '0;
            res.status = ST_OK;
            removed = 0;
            beats_in++;
            case (op)
                OP_ENQUEUE: begin
                    if (held >= DEPTH) begin
                        res.status = ST_FULL;
                        full_hits++;
                    end else begin
                        words[(head + held) % DEPTH] = val;
                        held++;
                    end
                end
                OP_DEQUEUE: begin
                    if (held == 0) begin
                        res.status = ST_EMPTY;
                        empty_hits++;
                    end else begin
                        res.data_out = words[head];
                        head = (head + 1) % DEPTH;
                        held--;
                    end
                end
                OP_PURGE: begin
                    // survivors are packed toward the head in their old order
                    kept = 0;
                    for (int i = 0; i < held; i++) begin
                        w = words[(head + i) % DEPTH];
                        if (w == val) begin
                            removed++;
                        end else begin
                            words[(head + kept) % DEPTH] = w;
                            kept++;
                        end
                    end
                    held = kept;
                    if (removed > 0) purge_hits++;
                    if (removed > most_removed) most_removed = removed;
                end
                default: ;
            endcase
            res.removed_count = OUT_W'(removed);
            res.occupancy     = OUT_W'(held);
            pending_results.push_back(res);
        endfunction

        function void check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
                end
            end
        endfunction

        function void check_result(logic [RES_W-1:0] beat);
            result_t got;
            result_t want;
            got = beat;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d arrived with nothing outstanding: %h", results_seen, beat);
                end
            end else begin
                want = pending_results.pop_front();
                check_field("data_out", want.data_out, got.data_out);
                check_field("status", WORD_W'(want.status), WORD_W'(got.status));
                check_field("removed_count", WORD_W'(want.removed_count),
                            WORD_W'(got.removed_count));
                check_field("occupancy", WORD_W'(want.occupancy), WORD_W'(got.occupancy));
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [WORD_W-1:0]   s_tdata;
    logic [1:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [RES_W-1:0]    m_tdata;

    purge_fifo_mirror    board = new();
    bit                  steady;
    logic [WORD_W-1:0]   value_pool [8];

    fifo_queue_with_purge_by_value dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic bit stall_now();
        return !steady && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // result side: check every accepted beat, then stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) board.check_result(m_tdata);
            m_tready <= !stall_now();
        end
    end

    // enters and leaves at a rising edge; valid stays high into the next beat if no gap
    task automatic send_beat(input logic [1:0] op, input logic [WORD_W-1:0] val);
        while (stall_now()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.take_beat(op, val);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
    endtask

    function automatic logic [WORD_W-1:0] pick_value(bit from_pool);
        if (from_pool || $urandom_range(0, 1)) begin
            return value_pool[$urandom_range(0, 7)];
        end
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_op(int mode);
        int roll;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                if (roll < 70) return OP_ENQUEUE;
                if (roll < 82) return OP_DEQUEUE;
                if (roll < 97) return OP_PURGE;
            end
            MODE_DRAIN: begin
                if (roll < 20) return OP_ENQUEUE;
                if (roll < 80) return OP_DEQUEUE;
                if (roll < 97) return OP_PURGE;
            end
            default: begin
                if (roll < 55) return OP_ENQUEUE;
                if (roll < 70) return OP_DEQUEUE;
                if (roll < 97) return OP_PURGE;
            end
        endcase
        return OP_UNUSED;
    endfunction

    task automatic run_segment(int mode);
        logic [WORD_W-1:0] v;
        if (mode == MODE_FLOOD) begin
            // empty the queue, overfill it with one word, then purge every copy
            v = pick_value(1'b1);
            while (board.held > 0) send_beat(OP_DEQUEUE, $urandom);
            repeat (DEPTH + 2) send_beat(OP_ENQUEUE, v);
            send_beat(OP_PURGE, v);
        end else begin
            repeat (SEG_BEATS) send_beat(pick_op(mode), pick_value(mode == MODE_PURGE));
        end
    endtask

    initial begin
        int seg;
        int random_start;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_ENQUEUE;
        aresetn  <= 1'b0;
        steady   = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty cases, word extremes, purges hitting head, tail and nothing
        send_beat(OP_DEQUEUE, 32'h0000_0000);
        send_beat(OP_PURGE,   32'h0000_0000);
        send_beat(OP_UNUSED,  32'h0000_0000);
        send_beat(OP_ENQUEUE, 32'h8000_0000);
        send_beat(OP_ENQUEUE, 32'h7FFF_FFFF);
        send_beat(OP_ENQUEUE, 32'h0000_0000);
        send_beat(OP_ENQUEUE, 32'hFFFF_FFFF);
        send_beat(OP_ENQUEUE, 32'h8000_0000);
        send_beat(OP_ENQUEUE, 32'h0000_0005);
        send_beat(OP_PURGE,   32'h1234_5678);
        send_beat(OP_PURGE,   32'h8000_0000);
        send_beat(OP_PURGE,   32'h0000_0005);
        send_beat(OP_UNUSED,  32'hAAAA_AAAA);
        send_beat(OP_DEQUEUE, 32'h0000_0000);
        send_beat(OP_ENQUEUE, 32'h0000_0000);
        send_beat(OP_PURGE,   32'h0000_0000);
        send_beat(OP_DEQUEUE, 32'h5555_5555);
        send_beat(OP_DEQUEUE, 32'h0000_0000);
        send_beat(OP_ENQUEUE, 32'h5555_5555);
        send_beat(OP_DEQUEUE, 32'hAAAA_AAAA);
        drain_results();

        // random: segments biased toward filling, draining, purging or flooding
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        random_start = board.beats_in;
        seg = 0;
        while (board.beats_in - random_start < RANDOM_BEATS) begin
            for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
            steady = (seg >= 10 && seg < 15);
            run_segment((seg % 7 == 3) ? MODE_FLOOD : $urandom_range(MODE_FILL, MODE_PURGE));
            if (seg % 5 == 4) drain_results();
            seg++;
        end
        steady = 1'b0;
        drain_results();
        repeat (2 * DEPTH + 10) @(posedge aclk);

        $display("%0d beats sent, %0d results checked; %0d full rejects, %0d empty reads,",
                 board.beats_in, board.results_seen, board.full_hits, board.empty_hits);
        $display("%0d purges that removed words, at most %0d words in one purge",
                 board.purge_hits, board.most_removed);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatches, %0d results outstanding",
                     board.mismatches, board.pending());
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(4_000_000);
        $display("timeout with %0d results outstanding", board.pending());
        $display("Mismatches found");
        $finish;
    end

endmodule
